// ----- sv/polygon_area_perimeter_macros.svh -----
// Assertion macros for the polygon area / perimeter block.
// Used by the checker; expects signals clk and rst_n in scope.
`ifndef POLYGON_AREA_PERIMETER_MACROS_SVH
`define POLYGON_AREA_PERIMETER_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PAP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pap_pkg.sv -----
// Package for the polygon area / perimeter block: field widths, defaults,
// and the status struct shared by the serial units. No dependencies.
`timescale 1ns / 1ps

package pap_pkg;

  localparam int COORD_W          = 16;  // vertex coordinate width
  localparam int MUL_W            = COORD_W + 1;  // signed operand width of the serial multiplier
  localparam int PROD_W           = 2 * MUL_W;
  localparam int CROSS_W          = 42;  // shoelace accumulator, wraps
  localparam int AREA_W           = 34;
  localparam int LEN_W            = 35;
  localparam int COUNT_W          = 11;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int FRAC_BITS_DEF    = 8;

  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse when the result is ready
  } unit_stat_t;

endpackage

// ----- sv/pap_if.sv -----
// Valid/ready channel interfaces for vertex input and polygon result.
// Depends on pap_pkg for field widths.
`timescale 1ns / 1ps

interface pap_in_if;
  import pap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      last;

  modport source (output valid, vertex_x, vertex_y, last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last, output ready);
endinterface

interface pap_out_if;
  import pap_pkg::*;

  logic               valid;
  logic               ready;
  logic [AREA_W-1:0]  twice_area;
  logic [LEN_W-1:0]   perimeter_fixed;
  logic [COUNT_W-1:0] vertex_count;
  logic               overflow;

  modport source (output valid, twice_area, perimeter_fixed, vertex_count, overflow,
                  input ready);
  modport sink   (input valid, twice_area, perimeter_fixed, vertex_count, overflow,
                  output ready);
endinterface

// ----- sv/pap_smul.sv -----
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on pap_pkg for the status struct.
`timescale 1ns / 1ps

module pap_smul #(
  parameter int W = pap_pkg::MUL_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [W-1:0]     a,
  input  logic signed [W-1:0]     b,
  output pap_pkg::unit_stat_t     stat,
  output logic signed [2*W-1:0]   prod
);
  import pap_pkg::*;

  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic signed [2*W-1:0] mcand_r;
  logic [W-1:0]          mplier_r;
  logic signed [2*W-1:0] acc_r;
  logic signed [2*W-1:0] acc_nxt;

  // The sign bit of the multiplier carries negative weight.
  always_comb begin
    acc_nxt = acc_r;
    if (mplier_r[0]) begin
      if (cnt_r == LAST_BIT) begin
        acc_nxt = acc_r - mcand_r;
      end else begin
        acc_nxt = acc_r + mcand_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_BIT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= {{W{a[W-1]}}, a};
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= acc_nxt;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

// ----- sv/pap_sqrt.sv -----
// Restoring integer square root, one root bit per cycle, radicand shifted
// in two bits at a time. Depends on pap_pkg for the status struct.
`timescale 1ns / 1ps

module pap_sqrt #(
  parameter int RW = pap_pkg::COORD_W + 1 + pap_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*RW-1:0]     rad,
  output pap_pkg::unit_stat_t stat,
  output logic [RW-1:0]       root
);
  import pap_pkg::*;

  localparam int CNT_W = $clog2(RW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RW - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [2*RW-1:0]   rad_r;
  logic [RW-1:0]     rem_r;
  logic [RW-1:0]     rem_nxt;
  logic [RW-1:0]     root_r;
  logic [RW-1:0]     root_nxt;
  logic [RW+1:0]     rem_sh;
  logic [RW+1:0]     trial;
  logic [RW+2:0]     diff;

  // Remainder stays below 2^RW on every step but the last, whose remainder
  // is dropped, so RW bits of it suffice.
  always_comb begin
    rem_sh = {rem_r, rad_r[2*RW-1 -: 2]};
    trial  = {root_r, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    if (!diff[RW+2]) begin
      rem_nxt  = diff[RW-1:0];
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[RW-1:0];
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

// ----- sv/polygon_area_perimeter.sv -----
// Polygon area and perimeter: top level, edge sequencer and accumulators.
// Depends on pap_pkg, pap_if, pap_smul and pap_sqrt.
//
// Usage:
//   in_vtx carries one vertex per beat (vertex_x, vertex_y, last). The beat
//   with last set closes the polygon, and one beat then appears on out_res
//   with twice the absolute shoelace area, the perimeter with FRAC_BITS
//   fractional bits, the vertex count and the overflow flag.
//   Each edge runs four bit-serial multipliers side by side and then the
//   restoring square root, whose loop is the longer of the two steps. The
//   last vertex also runs the closing edge to the first vertex before its
//   result is produced. One vertex is in work at a time; in_vtx.ready is
//   high only between vertices. The result sits in an output register, so
//   the next polygon starts while an earlier result waits; if out_res is
//   stalled when the following result is done, the sequencer holds until
//   it is taken. Synchronous reset (rst_n low) clears all polygon state
//   and drops out_res.valid.
`timescale 1ns / 1ps

module polygon_area_perimeter #(
  parameter int MAX_VERTICES = pap_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = pap_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pap_in_if.sink        in_vtx,
  pap_out_if.source     out_res
);
  import pap_pkg::*;

  localparam int RW    = COORD_W + 1 + FRAC_BITS;
  localparam int RAD_W = 2 * RW;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_VERTICES);
  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [CROSS_W-1:0]        cross_r;
  logic [LEN_W-1:0]          len_r;
  logic [CNT_W-1:0]          seen_r;
  logic                      too_many_r;
  logic                      last_r;
  logic                      closing_r;

  logic                      out_valid_r;
  logic [AREA_W-1:0]         out_area_r;
  logic [LEN_W-1:0]          out_len_r;
  logic [COUNT_W-1:0]        out_cnt_r;
  logic                      out_ovf_r;

  logic                      in_acc;
  logic                      mul_start;
  logic                      mul_done;
  logic                      sqrt_start;
  logic                      close_start;
  logic                      fin_load;

  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic signed [MUL_W-1:0]   dx_raw, dy_raw, dx, dy;
  logic signed [MUL_W-1:0]   ma [4];
  logic signed [MUL_W-1:0]   mb [4];
  logic signed [PROD_W-1:0]  mp [4];
  unit_stat_t                mstat [4];
  unit_stat_t                sstat;
  logic [PROD_W-1:0]         sq_sum;
  logic [RAD_W-1:0]          rad;
  logic [RW-1:0]             root;

  logic [CROSS_W-1:0]        cross_nxt;
  logic [LEN_W:0]            len_sum;
  logic [CROSS_W-1:0]        mag;
  logic [AREA_W-1:0]         area;
  logic [CNT_W+COUNT_W-1:0]  cnt_ext;

  assign in_vtx.ready = (state_r == ST_IDLE);
  assign in_acc       = in_vtx.valid && in_vtx.ready;

  // Edge operands: (prev -> cur) on a new vertex, (cur -> first) for closing.
  always_comb begin
    if (state_r == ST_IDLE) begin
      ax = (seen_r == '0) ? in_vtx.vertex_x : prev_x_r;
      ay = (seen_r == '0) ? in_vtx.vertex_y : prev_y_r;
      bx = in_vtx.vertex_x;
      by = in_vtx.vertex_y;
    end else begin
      ax = prev_x_r;
      ay = prev_y_r;
      bx = first_x_r;
      by = first_y_r;
    end
  end

  assign dx_raw = MUL_W'(ax) - MUL_W'(bx);
  assign dy_raw = MUL_W'(ay) - MUL_W'(by);
  assign dx     = dx_raw[MUL_W-1] ? -dx_raw : dx_raw;
  assign dy     = dy_raw[MUL_W-1] ? -dy_raw : dy_raw;

  assign ma[0] = MUL_W'(ax);
  assign mb[0] = MUL_W'(by);
  assign ma[1] = MUL_W'(bx);
  assign mb[1] = MUL_W'(ay);
  assign ma[2] = dx;
  assign mb[2] = dx;
  assign ma[3] = dy;
  assign mb[3] = dy;

  assign close_start = (state_r == ST_SQRT) && sstat.done && last_r && !closing_r;
  assign mul_start   = in_acc || close_start;
  assign mul_done    = mstat[0].done && mstat[1].done && mstat[2].done && mstat[3].done;
  assign sqrt_start  = (state_r == ST_MUL) && mul_done;
  assign fin_load    = (state_r == ST_FIN) && (!out_valid_r || out_res.ready);

  for (genvar i = 0; i < 4; i++) begin : g_mul
    pap_smul #(.W(MUL_W)) u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mul_start),
      .a     (ma[i]),
      .b     (mb[i]),
      .stat  (mstat[i]),
      .prod  (mp[i])
    );
  end

  // Squares are non-negative, so their sum fits the product width unsigned.
  assign sq_sum = $unsigned(mp[2]) + $unsigned(mp[3]);
  assign rad    = RAD_W'(sq_sum) << (2 * FRAC_BITS);

  pap_sqrt #(.RW(RW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (rad),
    .stat  (sstat),
    .root  (root)
  );

  assign cross_nxt = cross_r + CROSS_W'(mp[0]) - CROSS_W'(mp[1]);
  assign len_sum   = {1'b0, len_r} + (LEN_W + 1)'(root);

  // Magnitude of the wrapped shoelace sum; the most negative code maps to 2^41.
  assign mag     = cross_r[CROSS_W-1] ? (~cross_r + 1'b1) : cross_r;
  assign area    = (|mag[CROSS_W-1:AREA_W]) ? AREA_MAX : mag[AREA_W-1:0];
  assign cnt_ext = {{COUNT_W{1'b0}}, seen_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  if (mul_done) state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sstat.done) begin
          priority if (close_start) state_nxt = ST_MUL;
          else if (closing_r)       state_nxt = ST_FIN;
          else                      state_nxt = ST_IDLE;
        end
      end
      ST_FIN:  if (fin_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      first_x_r  <= '0;
      first_y_r  <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      cross_r    <= '0;
      len_r      <= '0;
      seen_r     <= '0;
      too_many_r <= 1'b0;
      last_r     <= 1'b0;
      closing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (seen_r == '0) begin
          first_x_r <= in_vtx.vertex_x;
          first_y_r <= in_vtx.vertex_y;
        end
        prev_x_r <= in_vtx.vertex_x;
        prev_y_r <= in_vtx.vertex_y;
        last_r   <= in_vtx.last;
        if (seen_r >= CNT_MAX) begin
          too_many_r <= 1'b1;
        end else begin
          seen_r <= seen_r + 1'b1;
        end
      end
      if (sqrt_start) begin
        cross_r <= cross_nxt;
      end
      if ((state_r == ST_SQRT) && sstat.done) begin
        len_r <= len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
      end
      if (close_start) begin
        closing_r <= 1'b1;
      end
      if (fin_load) begin
        first_x_r  <= '0;
        first_y_r  <= '0;
        prev_x_r   <= '0;
        prev_y_r   <= '0;
        cross_r    <= '0;
        len_r      <= '0;
        seen_r     <= '0;
        too_many_r <= 1'b0;
        last_r     <= 1'b0;
        closing_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_area_r <= area;
      out_len_r  <= len_r;
      out_cnt_r  <= cnt_ext[COUNT_W-1:0];
      out_ovf_r  <= too_many_r;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.twice_area      = out_area_r;
  assign out_res.perimeter_fixed = out_len_r;
  assign out_res.vertex_count    = out_cnt_r;
  assign out_res.overflow        = out_ovf_r;

endmodule

// ----- sv/pap_checker.sv -----
// Port-level checker for polygon_area_perimeter, bound to the top level.
// Depends on pap_pkg and polygon_area_perimeter_macros.svh.
`timescale 1ns / 1ps
`include "polygon_area_perimeter_macros.svh"

module pap_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pap_pkg::AREA_W-1:0]  twice_area,
  input logic [pap_pkg::LEN_W-1:0]   perimeter_fixed,
  input logic [pap_pkg::COUNT_W-1:0] vertex_count,
  input logic                        overflow
);
  import pap_pkg::*;

  // Reset empties the output register.
  `PAP_ASSERT_RST(a_reset_drops_valid, !rst_n |=> !out_valid, "out valid after reset")

  // A stalled result beat holds.
  `PAP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(twice_area) && $stable(perimeter_fixed) && $stable(vertex_count) && $stable(overflow), "stalled result changed")

  // One vertex in work at a time: ready drops right after an accepted beat.
  `PAP_ASSERT(a_one_vertex, in_valid && in_ready |=> !in_ready, "input accepted back to back")

  // Every polygon has at least one vertex.
  `PAP_ASSERT(a_count_nonzero, out_valid |-> vertex_count != '0, "result with zero vertices")

endmodule

bind polygon_area_perimeter pap_checker u_pap_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_vtx.valid),
  .in_ready        (in_vtx.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .twice_area      (out_res.twice_area),
  .perimeter_fixed (out_res.perimeter_fixed),
  .vertex_count    (out_res.vertex_count),
  .overflow        (out_res.overflow)
);
